/* hdl/lcd_window_fill_sequencer_unit_defines.svh */
// Assertion macros shared by the window fill sequencer files.
`ifndef LCD_WINDOW_FILL_SEQUENCER_UNIT_DEFINES_SVH
`define LCD_WINDOW_FILL_SEQUENCER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LCDWF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LCDWF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lcdwf_pkg.sv */
// Shared types and constants of the window fill sequencer.
`default_nettype none
package lcdwf_pkg;

  localparam int CW = 10;

  localparam logic [2:0] REG_ROTATION    = 3'd0;
  localparam logic [2:0] REG_HORIZ_START = 3'd1;
  localparam logic [2:0] REG_HORIZ_END   = 3'd2;
  localparam logic [2:0] REG_VERT_START  = 3'd3;
  localparam logic [2:0] REG_VERT_END    = 3'd4;
  localparam logic [2:0] REG_ADDR_X      = 3'd5;
  localparam logic [2:0] REG_ADDR_Y      = 3'd6;
  localparam logic [2:0] REG_MEM_WRITE   = 3'd7;

  localparam logic [1:0] OP_FILL   = 2'd0;
  localparam logic [1:0] OP_WINDOW = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    K_PIXEL,
    K_ERROR,
    K_WINDOW,
    K_FILL
  } kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [15:0] pix;
  } req_t;

  typedef struct packed {
    kind_e          kind;
    logic [CW-1:0]  hs;
    logic [CW-1:0]  he;
    logic [CW-1:0]  vs;
    logic [CW-1:0]  ve;
    logic [CW-1:0]  ay;
    logic [15:0]    pix;
    logic [15:0]    run;
  } win_t;

  typedef struct packed {
    logic       rotation;
    logic [7:0] cmd_hs;
    logic [7:0] cmd_he;
    logic [7:0] cmd_vs;
    logic [7:0] cmd_ve;
    logic [7:0] cmd_ax;
    logic [7:0] cmd_ay;
    logic [7:0] cmd_mw;
  } cfg_t;

endpackage
`default_nettype wire

/* hdl/lcdwf_geom.sv */
// Two pipeline stages that check the rectangle and map it into window bounds.
`default_nettype none
module lcdwf_geom #(
  parameter int PANEL_MAX_X = 175,
  parameter int PANEL_MAX_Y = 219
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  lcdwf_pkg::req_t     in_req_i,
  input  wire                 rotation_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output lcdwf_pkg::win_t     out_win_o
);

  localparam int CW = lcdwf_pkg::CW;
  localparam logic [CW-1:0] MAXX = CW'(PANEL_MAX_X);
  localparam logic [CW-1:0] MAXY = CW'(PANEL_MAX_Y);

  logic           a_valid_q;
  logic [1:0]     a_op_q;
  logic [CW-1:0]  a_x_q, a_y_q, a_xe_q, a_ye_q;
  logic [17:0]    a_run_q;
  logic           a_bad_q;
  logic [15:0]    a_pix_q;
  logic           a_ready, b_ready;

  logic           b_valid_q;
  lcdwf_pkg::win_t b_win_q, b_win_d;
  logic           range_err;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_op_q  <= in_req_i.op;
      a_x_q   <= CW'(in_req_i.x);
      a_y_q   <= CW'(in_req_i.y);
      a_xe_q  <= CW'(in_req_i.x) + CW'(in_req_i.w) - CW'(1);
      a_ye_q  <= CW'(in_req_i.y) + CW'(in_req_i.h) - CW'(1);
      a_run_q <= 18'(in_req_i.w) * 18'(in_req_i.h);
      a_bad_q <= (in_req_i.op == lcdwf_pkg::OP_UNUSED) || (in_req_i.w == 9'd0) ||
                 (in_req_i.h == 9'd0);
      a_pix_q <= in_req_i.pix;
    end
  end

  always_comb begin
    b_win_d     = '0;
    b_win_d.pix = a_pix_q;
    b_win_d.run = (|a_run_q[17:16]) ? 16'hFFFF : a_run_q[15:0];
    if (!rotation_i) begin
      range_err  = (a_xe_q > MAXX) || (a_ye_q > MAXY);
      b_win_d.hs = a_x_q;
      b_win_d.he = a_xe_q;
      b_win_d.vs = MAXY - a_ye_q;
      b_win_d.ve = MAXY - a_y_q;
      b_win_d.ay = MAXY - a_ye_q;
    end else begin
      range_err  = (a_ye_q > MAXX) || (a_xe_q > MAXY);
      b_win_d.hs = MAXX - a_ye_q;
      b_win_d.he = MAXX - a_y_q;
      b_win_d.vs = MAXY - a_xe_q;
      b_win_d.ve = MAXY - a_x_q;
      b_win_d.ay = MAXY - a_x_q;
    end
    if (a_op_q == lcdwf_pkg::OP_PIXEL) begin
      b_win_d.kind = lcdwf_pkg::K_PIXEL;
    end else if (a_bad_q || range_err) begin
      b_win_d.kind = lcdwf_pkg::K_ERROR;
    end else if (a_op_q == lcdwf_pkg::OP_WINDOW) begin
      b_win_d.kind = lcdwf_pkg::K_WINDOW;
    end else begin
      b_win_d.kind = lcdwf_pkg::K_FILL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_win_q <= b_win_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_win_o   = b_win_q;

endmodule
`default_nettype wire

/* hdl/lcdwf_emit.sv */
// Word sequencer that walks one request through its bus words into the output register.
`default_nettype none
module lcdwf_emit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  lcdwf_pkg::win_t     in_win_i,
  input  lcdwf_pkg::cfg_t     cfg_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_is_data_o,
  output logic [15:0]         out_word_o,
  output logic [15:0]         out_rep_o,
  output logic                out_err_o,
  output logic                out_last_o
);

  localparam int CW = lcdwf_pkg::CW;

  typedef enum logic [3:0] {
    S_HS_CMD, S_HS_DAT, S_HE_CMD, S_HE_DAT, S_AX_CMD, S_AX_DAT,
    S_VS_CMD, S_VS_DAT, S_VE_CMD, S_VE_DAT, S_AY_CMD, S_AY_DAT,
    S_MW_CMD, S_RUN
  } slot_e;

  logic            busy_q;
  slot_e           slot_q;
  lcdwf_pkg::win_t item_q;

  logic            out_valid_q, is_data_q, err_q, last_q;
  logic [15:0]     word_q, rep_q;

  logic            w_is_data, w_err, w_last;
  logic [15:0]     w_word, w_rep;
  logic            out_free, emit, done, load;

  function automatic logic [15:0] ext(input logic [CW-1:0] v);
    ext = {{(16 - CW){1'b0}}, v};
  endfunction

  always_comb begin
    w_is_data = 1'b0;
    w_word    = '0;
    w_rep     = 16'd1;
    w_err     = 1'b0;
    w_last    = 1'b0;
    unique case (slot_q)
      S_HS_CMD: w_word = {8'd0, cfg_i.cmd_hs};
      S_HS_DAT: begin w_is_data = 1'b1; w_word = ext(item_q.hs); end
      S_HE_CMD: w_word = {8'd0, cfg_i.cmd_he};
      S_HE_DAT: begin w_is_data = 1'b1; w_word = ext(item_q.he); end
      S_AX_CMD: w_word = {8'd0, cfg_i.cmd_ax};
      S_AX_DAT: begin w_is_data = 1'b1; w_word = ext(item_q.hs); end
      S_VS_CMD: w_word = {8'd0, cfg_i.cmd_vs};
      S_VS_DAT: begin w_is_data = 1'b1; w_word = ext(item_q.vs); end
      S_VE_CMD: w_word = {8'd0, cfg_i.cmd_ve};
      S_VE_DAT: begin w_is_data = 1'b1; w_word = ext(item_q.ve); end
      S_AY_CMD: w_word = {8'd0, cfg_i.cmd_ay};
      S_AY_DAT: begin w_is_data = 1'b1; w_word = ext(item_q.ay); end
      S_MW_CMD: begin
        w_word = {8'd0, cfg_i.cmd_mw};
        w_last = (item_q.kind == lcdwf_pkg::K_WINDOW);
      end
      S_RUN: begin
        w_is_data = 1'b1;
        w_word    = item_q.pix;
        w_rep     = item_q.run;
        w_last    = 1'b1;
      end
      default: ;
    endcase
    if (item_q.kind == lcdwf_pkg::K_PIXEL) begin
      w_is_data = 1'b1;
      w_word    = item_q.pix;
      w_rep     = 16'd1;
      w_last    = 1'b1;
    end else if (item_q.kind == lcdwf_pkg::K_ERROR) begin
      w_is_data = 1'b0;
      w_word    = '0;
      w_rep     = '0;
      w_err     = 1'b1;
      w_last    = 1'b1;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = busy_q && out_free;
  assign done       = emit && w_last;
  assign in_ready_o = !busy_q || done;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= S_HS_CMD;
      out_valid_q <= 1'b0;
      is_data_q   <= 1'b0;
      word_q      <= '0;
      rep_q       <= '0;
      err_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        slot_q <= S_HS_CMD;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        slot_q <= slot_e'(4'(slot_q) + 4'd1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        is_data_q   <= w_is_data;
        word_q      <= w_word;
        rep_q       <= w_rep;
        err_q       <= w_err;
        last_q      <= w_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_win_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_is_data_o = is_data_q;
  assign out_word_o    = word_q;
  assign out_rep_o     = rep_q;
  assign out_err_o     = err_q;
  assign out_last_o    = last_q;

endmodule
`default_nettype wire

/* hdl/lcd_window_fill_sequencer_unit.sv */
// Top level of the panel window fill sequencer with its configuration registers.
//
//  Channel  Direction  Handshake              Content
//  s_*      in         s_tvalid/s_tready      drawing request, opcode in tuser
//  m_*      out        m_tvalid/m_tready      bus word, is_data in tuser, tlast
//  cfg_*    in         cfg_we_i               register write, no wait
//
// A request passes two check and mapping stages, then the word sequencer,
// which puts one word per cycle into the output register while the output is not stalled.
// A fill emits fourteen words, an open window thirteen, a pixel or an error one;
// the sequencer takes the next request as the last word of the current one goes out.
// The first word passes both stages, the item register and the output register.
// Reset restores the register defaults and empties every stage at once.
// Stalls on the output hold each stage in place; nothing is lost or repeated.
`default_nettype none
`include "lcd_window_fill_sequencer_unit_defines.svh"
module lcd_window_fill_sequencer_unit #(
  parameter int PANEL_MAX_X = 175,
  parameter int PANEL_MAX_Y = 219
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_tvalid,
  output logic         s_tready,
  // x_start[7:0], y_start[15:8], width[24:16], height[33:25], pixel_value[49:34]
  input  wire  [55:0]  s_tdata,
  // opcode[1:0]
  input  wire  [1:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // bus_word[15:0], repeat_count[31:16], error[32]
  output logic [39:0]  m_tdata,
  // is_data[0]
  output logic         m_tuser,
  output logic         m_tlast,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [7:0]   cfg_data_i
);

  lcdwf_pkg::cfg_t cfg_q;
  lcdwf_pkg::req_t req;
  lcdwf_pkg::win_t win;
  logic            win_valid, win_ready;
  logic            o_is_data, o_err, o_last;
  logic [15:0]     o_word, o_rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation <= 1'b0;
      cfg_q.cmd_hs   <= 8'd55;
      cfg_q.cmd_he   <= 8'd54;
      cfg_q.cmd_vs   <= 8'd57;
      cfg_q.cmd_ve   <= 8'd56;
      cfg_q.cmd_ax   <= 8'd32;
      cfg_q.cmd_ay   <= 8'd33;
      cfg_q.cmd_mw   <= 8'd34;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcdwf_pkg::REG_ROTATION:    cfg_q.rotation <= cfg_data_i[0];
        lcdwf_pkg::REG_HORIZ_START: cfg_q.cmd_hs   <= cfg_data_i;
        lcdwf_pkg::REG_HORIZ_END:   cfg_q.cmd_he   <= cfg_data_i;
        lcdwf_pkg::REG_VERT_START:  cfg_q.cmd_vs   <= cfg_data_i;
        lcdwf_pkg::REG_VERT_END:    cfg_q.cmd_ve   <= cfg_data_i;
        lcdwf_pkg::REG_ADDR_X:      cfg_q.cmd_ax   <= cfg_data_i;
        lcdwf_pkg::REG_ADDR_Y:      cfg_q.cmd_ay   <= cfg_data_i;
        lcdwf_pkg::REG_MEM_WRITE:   cfg_q.cmd_mw   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req.op  = s_tuser;
  assign req.x   = s_tdata[7:0];
  assign req.y   = s_tdata[15:8];
  assign req.w   = s_tdata[24:16];
  assign req.h   = s_tdata[33:25];
  assign req.pix = s_tdata[49:34];

  lcdwf_geom #(
    .PANEL_MAX_X (PANEL_MAX_X),
    .PANEL_MAX_Y (PANEL_MAX_Y)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_req_i    (req),
    .rotation_i  (cfg_q.rotation),
    .out_valid_o (win_valid),
    .out_ready_i (win_ready),
    .out_win_o   (win)
  );

  lcdwf_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (win_valid),
    .in_ready_o    (win_ready),
    .in_win_i      (win),
    .cfg_i         (cfg_q),
    .out_valid_o   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_is_data_o (o_is_data),
    .out_word_o    (o_word),
    .out_rep_o     (o_rep),
    .out_err_o     (o_err),
    .out_last_o    (o_last)
  );

  assign m_tdata = {7'd0, o_err, o_rep, o_word};
  assign m_tuser = o_is_data;
  assign m_tlast = o_last;

  `LCDWF_ASSERT_IMP(a_err_single, m_tvalid && o_err, o_last && !o_is_data && ~|o_rep, "bad error word")
  `LCDWF_ASSERT_IMP(a_run_last, m_tvalid && (o_rep != 16'd1), o_last, "repeat only on the closing word")
  `LCDWF_ASSERT_NXT(a_seq_gapless, m_tvalid && m_tready && !o_last, m_tvalid, "gap in a sequence")

endmodule
`default_nettype wire
